FILE: design/tsiu_pkg.sv
package tsiu_pkg;

    typedef logic [1:0] t_cmd;

    localparam t_cmd CMD_CLEAR   = 2'd0;
    localparam t_cmd CMD_LOAD_A  = 2'd1;
    localparam t_cmd CMD_LOAD_B  = 2'd2;
    localparam t_cmd CMD_COMPUTE = 2'd3;

    localparam logic REG_OPERATION = 1'b0;
    localparam logic REG_NORMALIZE = 1'b1;

    localparam int VERT_W = 16;

endpackage

FILE: design/tsiu_ram.sv
module tsiu_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/triangle_set_intersect_union_unit.sv
// Triangle set intersection / union unit.
// Request channel (i_in_valid / o_in_ready) carries a command and a triangle:
// clear both sets, load into set A, load into set B, or compute.
// Config channel (i_cfg_valid / o_cfg_ready) writes operation (0 intersect,
// 1 union) and normalize_on_load; always ready, write only while idle.
// Result channel (o_out_valid / i_out_ready) returns result triangles of a
// compute, last_item on the final one; an empty result gives one marker.
// Sets are kept sorted on load by insertion into per-set RAMs through one
// shared triangle comparator: a load keeps o_in_ready low while it steps
// through check and compare states, moving one larger entry up per step;
// clear and dropped loads keep it high. Compute is a merge through check and
// compare states; union first emits all of A, then the B entries not in A.
// o_in_ready is low while a load or compute runs.
// When the receiver stalls, the merge waits on the single output register.
// Reset empties both sets, clears the overflow flag, the config and valid flags.
module triangle_set_intersect_union_unit
    import tsiu_pkg::*;
#(
    parameter int SET_CAPACITY = 32,
    parameter int INDEX_BITS   = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic              i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_cmd              i_cmd,
    input  logic [VERT_W-1:0] i_vert_first,
    input  logic [VERT_W-1:0] i_vert_second,
    input  logic [VERT_W-1:0] i_vert_third,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [VERT_W-1:0] o_out_first,
    output logic [VERT_W-1:0] o_out_second,
    output logic [VERT_W-1:0] o_out_third,
    output logic              o_has_triangle,
    output logic              o_last_item,
    output logic              o_overflowed
);

    localparam int IB = INDEX_BITS;
    localparam int DW = 3 * IB;
    localparam int AW = $clog2(SET_CAPACITY);
    localparam int CW = $clog2(SET_CAPACITY + 1);
    localparam logic [CW-1:0] CAP = CW'(SET_CAPACITY);
    localparam logic [VERT_W-1:0] IMASK =
        (IB >= VERT_W) ? {VERT_W{1'b1}} : VERT_W'((1 << IB) - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LCHK = 3'd1;
    localparam logic [2:0] S_LCMP = 3'd2;
    localparam logic [2:0] S_MCHK = 3'd3;
    localparam logic [2:0] S_MCMP = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]    r_st;
    logic          r_op, r_norm, r_ofl, r_set, r_ph;
    logic [CW-1:0] r_cnt_a, r_cnt_b, r_j, r_ia, r_ib;
    logic [DW-1:0] r_key, r_h;
    logic          r_hv;
    logic          r_ov;
    logic [VERT_W-1:0] r_o1, r_o2, r_o3;
    logic          r_oh, r_ol, r_oo;

    logic [IB-1:0] w_v0, w_v1, w_v2;
    logic [DW-1:0] w_nkey;
    logic [CW-1:0] w_jm1;
    logic          w_load;
    logic [AW-1:0] w_ra_a, w_ra_b;
    logic [DW-1:0] w_rd_a, w_rd_b, w_rd_sel, w_x, w_y, w_wdata;
    logic          w_we_a, w_we_b, w_lt, w_eq;
    logic          w_ofree, w_emit, w_go, w_push;
    logic [DW-1:0] w_etri;

    assign w_v0 = IB'(i_vert_first & IMASK);
    assign w_v1 = IB'(i_vert_second & IMASK);
    assign w_v2 = IB'(i_vert_third & IMASK);

    always_comb begin
        w_nkey = {w_v0, w_v1, w_v2};
        if (r_norm) begin
            if (w_v0 > w_v1) begin
                if (w_v1 > w_v2) w_nkey = {w_v2, w_v0, w_v1};
                else             w_nkey = {w_v1, w_v2, w_v0};
            end else if (w_v0 > w_v2) begin
                w_nkey = {w_v2, w_v0, w_v1};
            end
        end
    end

    assign w_jm1  = r_j - 1'b1;
    assign w_load = (r_st == S_LCHK) || (r_st == S_LCMP);
    assign w_ra_a = w_load ? w_jm1[AW-1:0] : r_ia[AW-1:0];
    assign w_ra_b = w_load ? w_jm1[AW-1:0] : r_ib[AW-1:0];

    assign w_rd_sel = r_set ? w_rd_b : w_rd_a;
    assign w_x = (r_st == S_LCMP) ? r_key : w_rd_a;
    assign w_y = (r_st == S_LCMP) ? w_rd_sel : w_rd_b;
    assign w_lt = w_x < w_y;
    assign w_eq = w_x == w_y;

    assign w_wdata = ((r_st == S_LCMP) && w_lt) ? w_rd_sel : r_key;
    assign w_we_a = !r_set && (((r_st == S_LCHK) && (r_j == '0)) || (r_st == S_LCMP));
    assign w_we_b =  r_set && (((r_st == S_LCHK) && (r_j == '0)) || (r_st == S_LCMP));

    tsiu_ram #(.WIDTH(DW), .DEPTH(SET_CAPACITY)) u_ram_a (
        .i_clk(i_clk), .i_we(w_we_a), .i_waddr(r_j[AW-1:0]), .i_wdata(w_wdata),
        .i_raddr(w_ra_a), .o_rdata(w_rd_a)
    );

    tsiu_ram #(.WIDTH(DW), .DEPTH(SET_CAPACITY)) u_ram_b (
        .i_clk(i_clk), .i_we(w_we_b), .i_waddr(r_j[AW-1:0]), .i_wdata(w_wdata),
        .i_raddr(w_ra_b), .o_rdata(w_rd_b)
    );

    assign w_ofree = !r_ov || i_out_ready;

    always_comb begin
        w_emit = 1'b0;
        w_etri = w_rd_a;
        if (r_ph) begin
            w_emit = 1'b1;
        end else if (r_ia == r_cnt_a) begin
            w_emit = 1'b1;
            w_etri = w_rd_b;
        end else if (w_eq) begin
            w_emit = !r_op;
        end else if (!w_lt) begin
            w_emit = r_op;
            w_etri = w_rd_b;
        end
    end

    assign w_go   = !(w_emit && r_hv && !w_ofree);
    assign w_push = ((r_st == S_MCMP) && w_go && w_emit && r_hv) ||
                    ((r_st == S_FIN) && w_ofree);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_op    <= 1'b0;
            r_norm  <= 1'b0;
            r_ofl   <= 1'b0;
            r_cnt_a <= '0;
            r_cnt_b <= '0;
            r_hv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_OPERATION) r_op   <= i_cfg_data;
                else                              r_norm <= i_cfg_data;
            end
            r_ov <= w_push || (r_ov && !i_out_ready);
            if (w_push) begin
                r_oo <= r_ofl;
                if (r_hv) begin
                    r_o1 <= VERT_W'(r_h[DW-1 -: IB]);
                    r_o2 <= VERT_W'(r_h[2*IB-1 -: IB]);
                    r_o3 <= VERT_W'(r_h[IB-1:0]);
                    r_oh <= 1'b1;
                end else begin
                    r_o1 <= '0;
                    r_o2 <= '0;
                    r_o3 <= '0;
                    r_oh <= 1'b0;
                end
                r_ol <= (r_st == S_FIN);
            end
            unique case (r_st)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_key <= w_nkey;
                        unique case (i_cmd)
                            CMD_CLEAR: begin
                                r_cnt_a <= '0;
                                r_cnt_b <= '0;
                                r_ofl   <= 1'b0;
                            end
                            CMD_LOAD_A, CMD_LOAD_B: begin
                                r_set <= (i_cmd == CMD_LOAD_B);
                                r_j   <= (i_cmd == CMD_LOAD_B) ? r_cnt_b : r_cnt_a;
                                if (((i_cmd == CMD_LOAD_B) ? r_cnt_b : r_cnt_a) >= CAP) begin
                                    r_ofl <= 1'b1;
                                end else begin
                                    r_st <= S_LCHK;
                                end
                            end
                            default: begin
                                r_ia <= '0;
                                r_ib <= '0;
                                r_ph <= r_op;
                                r_st <= S_MCHK;
                            end
                        endcase
                    end
                end
                S_LCHK: begin
                    if (r_j == '0) begin
                        if (r_set) r_cnt_b <= r_cnt_b + 1'b1;
                        else       r_cnt_a <= r_cnt_a + 1'b1;
                        r_st <= S_IDLE;
                    end else begin
                        r_st <= S_LCMP;
                    end
                end
                S_LCMP: begin
                    if (w_lt) begin
                        r_j  <= w_jm1;
                        r_st <= S_LCHK;
                    end else begin
                        if (r_set) r_cnt_b <= r_cnt_b + 1'b1;
                        else       r_cnt_a <= r_cnt_a + 1'b1;
                        r_st <= S_IDLE;
                    end
                end
                S_MCHK: begin
                    if (r_ph) begin
                        if (r_ia == r_cnt_a) begin
                            r_ph <= 1'b0;
                            r_ia <= '0;
                        end else begin
                            r_st <= S_MCMP;
                        end
                    end else if (r_ib == r_cnt_b) begin
                        r_st <= S_FIN;
                    end else if ((r_ia == r_cnt_a) && !r_op) begin
                        r_st <= S_FIN;
                    end else begin
                        r_st <= S_MCMP;
                    end
                end
                S_MCMP: begin
                    if (w_go) begin
                        if (w_emit) begin
                            r_h  <= w_etri;
                            r_hv <= 1'b1;
                        end
                        if (r_ph) begin
                            r_ia <= r_ia + 1'b1;
                        end else if (r_ia == r_cnt_a) begin
                            r_ib <= r_ib + 1'b1;
                        end else if (w_eq) begin
                            r_ia <= r_ia + 1'b1;
                            r_ib <= r_ib + 1'b1;
                        end else if (w_lt) begin
                            r_ia <= r_ia + 1'b1;
                        end else begin
                            r_ib <= r_ib + 1'b1;
                        end
                        r_st <= S_MCHK;
                    end
                end
                S_FIN: begin
                    if (w_ofree) begin
                        r_hv <= 1'b0;
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_cfg_ready    = 1'b1;
    assign o_in_ready     = (r_st == S_IDLE);
    assign o_out_valid    = r_ov;
    assign o_out_first    = r_o1;
    assign o_out_second   = r_o2;
    assign o_out_third    = r_o3;
    assign o_has_triangle = r_oh;
    assign o_last_item    = r_ol;
    assign o_overflowed   = r_oo;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_a <= CAP) && (r_cnt_b <= CAP))
        else $error("set count beyond capacity");

    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_has_triangle) |-> o_last_item)
        else $error("empty marker without last_item");

    a_load_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_LCMP) |=> ((r_st == S_LCHK) || (r_st == S_IDLE)))
        else $error("insertion step left load sequence");

    a_hold_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_IDLE) |-> !r_hv)
        else $error("pending result left after compute");

endmodule
